[design/cep_pkg.sv]
// Shared types, constants and arithmetic helpers for the circle emitter position block.
`timescale 1ns / 1ps
`default_nettype none
package cep_pkg;

	localparam int COORD_WIDTH = 16;

	localparam int Z_W     = 25;
	localparam int XY_W    = 34;
	localparam int R_W     = 18;
	localparam int M_W     = 22;
	localparam int ACC_M_W = 36;
	localparam int PC_W    = R_W + XY_W;
	localparam int PROD_W  = M_W + COORD_WIDTH;
	localparam int SUM_W   = PROD_W + 2;

	localparam logic [16:0] DEG90  = 17'd5760;
	localparam logic [16:0] DEG180 = 17'd11520;
	localparam logic [16:0] DEG270 = 17'd17280;
	localparam logic [16:0] DEG360 = 17'd23040;

	localparam logic signed [XY_W-1:0] CORDIC_K = 34'sd652032874;
	localparam logic signed [ACC_M_W-1:0] ONE_Q28 = 36'sd268435456;

	// register indexes
	localparam logic [2:0] REG_MODE   = 3'd0;
	localparam logic [2:0] REG_STEP   = 3'd1;
	localparam logic [2:0] REG_START  = 3'd2;
	localparam logic [2:0] REG_FAN    = 3'd3;
	localparam logic [2:0] REG_RADII  = 3'd4;
	localparam logic [2:0] REG_WIDTHS = 3'd5;
	localparam logic [2:0] REG_ROT    = 3'd6;
	localparam logic [2:0] REG_OFF    = 3'd7;

	localparam logic [2:0]  RST_MODE   = 3'd1;
	localparam logic [14:0] RST_STEP   = 15'd640;
	localparam logic [14:0] RST_START  = 15'd0;
	localparam logic [31:0] RST_FAN    = 32'h5A00_0000;
	localparam logic [31:0] RST_RADII  = 32'h0800_0800;
	localparam logic [31:0] RST_WIDTHS = 32'h0040_0040;
	localparam logic [63:0] RST_ROT    = 64'h4000_0000_0000_0000;
	localparam logic [47:0] RST_OFF    = 48'h0;

	// plane codes in mode[2:1]; anything else is yz
	localparam logic [1:0] PLANE_XY = 2'd0;
	localparam logic [1:0] PLANE_XZ = 2'd1;

	// quaternion component codes
	localparam logic [1:0] Q_W = 2'd0;
	localparam logic [1:0] Q_X = 2'd1;
	localparam logic [1:0] Q_Y = 2'd2;
	localparam logic [1:0] Q_Z = 2'd3;

	typedef struct packed {
		logic [15:0] rand_angle;
		logic [15:0] rand_x;
		logic [15:0] rand_z;
	} request_t;

	typedef struct packed {
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] pos_z;
	} result_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [14:0] angle_step;
		logic [14:0] start_angle;
		logic [31:0] fan_angles;
		logic [31:0] radii;
		logic [31:0] ring_widths;
		logic [63:0] rotation;
		logic [47:0] offset;
	} cfg_t;

	typedef struct packed {
		logic signed [Z_W-1:0] z;
		logic                  neg;
		logic signed [R_W-1:0] r1;
		logic signed [R_W-1:0] r2;
	} front_item_t;

	typedef struct packed {
		logic [1:0] ia;
		logic [1:0] ib;
		logic [1:0] ic;
		logic [1:0] id;
		logic       diag;
		logic       neg2;
	} mat_op_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_RUN,
		BK_ROT,
		BK_FIN
	} back_state_t;

	function automatic logic signed [Z_W-1:0] atan_q(input logic [3:0] i);
		logic signed [Z_W-1:0] v;
		case (i)
			4'd0:    v = 25'sd2949120;
			4'd1:    v = 25'sd1740967;
			4'd2:    v = 25'sd919879;
			4'd3:    v = 25'sd466945;
			4'd4:    v = 25'sd234379;
			4'd5:    v = 25'sd117304;
			4'd6:    v = 25'sd58666;
			4'd7:    v = 25'sd29335;
			4'd8:    v = 25'sd14668;
			4'd9:    v = 25'sd7334;
			4'd10:   v = 25'sd3667;
			4'd11:   v = 25'sd1833;
			4'd12:   v = 25'sd917;
			4'd13:   v = 25'sd458;
			4'd14:   v = 25'sd229;
			default: v = 25'sd115;
		endcase
		return v;
	endfunction

	// rotation matrix entry k: base + s1*2*a*b + s2*2*c*d
	function automatic mat_op_t mat_op(input logic [3:0] k);
		mat_op_t o;
		case (k)
			4'd0:    o = '{Q_Y, Q_Y, Q_Z, Q_Z, 1'b1, 1'b1};
			4'd1:    o = '{Q_X, Q_Y, Q_W, Q_Z, 1'b0, 1'b1};
			4'd2:    o = '{Q_X, Q_Z, Q_W, Q_Y, 1'b0, 1'b0};
			4'd3:    o = '{Q_X, Q_Y, Q_W, Q_Z, 1'b0, 1'b0};
			4'd4:    o = '{Q_X, Q_X, Q_Z, Q_Z, 1'b1, 1'b1};
			4'd5:    o = '{Q_Y, Q_Z, Q_W, Q_X, 1'b0, 1'b1};
			4'd6:    o = '{Q_X, Q_Z, Q_W, Q_Y, 1'b0, 1'b1};
			4'd7:    o = '{Q_Y, Q_Z, Q_W, Q_X, 1'b0, 1'b0};
			default: o = '{Q_X, Q_X, Q_Y, Q_Y, 1'b1, 1'b1};
		endcase
		return o;
	endfunction

	function automatic logic signed [COORD_WIDTH-1:0] sat_cw(input logic signed [63:0] v);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
		lo = -hi - 64'sd1;
		if (v > hi) return hi[COORD_WIDTH-1:0];
		if (v < lo) return lo[COORD_WIDTH-1:0];
		return v[COORD_WIDTH-1:0];
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
		if (v > 64'sd32767) return 16'sh7FFF;
		if (v < -64'sd32768) return 16'sh8000;
		return v[15:0];
	endfunction

endpackage
`default_nettype wire

[design/circle_emitter_position.sv]
// Circle emitter position: register port, front part, request queue and back part.
// Per request the back part runs one load, 16 CORDIC iterations, the radius multiplies
// with the matrix build overlapped, 10 rotate steps and one finish; it reads no new
// request from the queue until it is back in idle, and a result left waiting stalls it.
// Reset (arst_n low): queues empty, contour angle 0, registers at their defaults.
`timescale 1ns / 1ps
`default_nettype none
module circle_emitter_position
	import cep_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire request_t    request,
	output logic             empty,
	input  wire logic        pop,
	output result_t          result,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [5:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0]      prdata,
	output logic             pready
);

	cfg_t        cfg_q;
	logic        wr;
	logic [2:0]  idx;
	logic        q_wr, q_full, q_rd, q_empty;
	front_item_t q_wdata, q_rdata;

	assign pready = 1'b1;
	assign idx    = paddr[5:3];
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode        <= RST_MODE;
			cfg_q.angle_step  <= RST_STEP;
			cfg_q.start_angle <= RST_START;
			cfg_q.fan_angles  <= RST_FAN;
			cfg_q.radii       <= RST_RADII;
			cfg_q.ring_widths <= RST_WIDTHS;
			cfg_q.rotation    <= RST_ROT;
			cfg_q.offset      <= RST_OFF;
		end else if (wr) begin
			unique case (idx)
				REG_MODE:   cfg_q.mode        <= pwdata[2:0];
				REG_STEP:   cfg_q.angle_step  <= pwdata[14:0];
				REG_START:  cfg_q.start_angle <= pwdata[14:0];
				REG_FAN:    cfg_q.fan_angles  <= pwdata[31:0];
				REG_RADII:  cfg_q.radii       <= pwdata[31:0];
				REG_WIDTHS: cfg_q.ring_widths <= pwdata[31:0];
				REG_ROT:    cfg_q.rotation    <= pwdata;
				default:    cfg_q.offset      <= pwdata[47:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_MODE:   prdata = {61'b0, cfg_q.mode};
			REG_STEP:   prdata = {49'b0, cfg_q.angle_step};
			REG_START:  prdata = {49'b0, cfg_q.start_angle};
			REG_FAN:    prdata = {32'b0, cfg_q.fan_angles};
			REG_RADII:  prdata = {32'b0, cfg_q.radii};
			REG_WIDTHS: prdata = {32'b0, cfg_q.ring_widths};
			REG_ROT:    prdata = cfg_q.rotation;
			default:    prdata = {16'b0, cfg_q.offset};
		endcase
	end

	cep_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.start_load (wr && idx == REG_START),
		.start_val  (pwdata[14:0]),
		.push       (push),
		.full       (full),
		.request    (request),
		.q_wr       (q_wr),
		.q_wdata    (q_wdata),
		.q_full     (q_full)
	);

	cep_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wdata  (q_wdata),
		.full   (q_full),
		.rd     (q_rd),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	cep_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_rdata (q_rdata),
		.q_empty (q_empty),
		.q_rd    (q_rd),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule
`default_nettype wire

[design/cep_queue.sv]
// Two-entry queue carrying classified requests from the front part to the back part.
`timescale 1ns / 1ps
`default_nettype none
module cep_queue
	import cep_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        wr,
	input  wire front_item_t wdata,
	output logic             full,
	input  wire logic        rd,
	output front_item_t      rdata,
	output logic             empty
);

	front_item_t mem_q [2];
	logic        wp_q;
	logic        rp_q;
	logic [1:0]  cnt_q;
	logic        wdone;
	logic        rdone;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign wdone = wr && !full;
	assign rdone = rd && !empty;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wdone) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wdone) begin
				wp_q <= !wp_q;
			end
			if (rdone) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + {1'b0, wdone} - {1'b0, rdone};
		end
	end

endmodule
`default_nettype wire

[design/cep_front.sv]
// Front part: takes spawn requests, picks the angle and radii, keeps the contour angle.
`timescale 1ns / 1ps
`default_nettype none
module cep_front
	import cep_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cfg_t        cfg,
	input  wire logic        start_load,
	input  wire logic [14:0] start_val,
	input  wire logic        push,
	output logic             full,
	input  wire request_t    request,
	output logic             q_wr,
	output front_item_t      q_wdata,
	input  wire logic        q_full
);

	logic        random;
	logic [15:0] st;
	logic [15:0] en;
	logic [15:0] span;
	logic [31:0] sp_full;
	logic signed [32:0] w1p_full;
	logic signed [32:0] w2p_full;
	logic [16:0] ca;
	logic        accept;

	logic [14:0] contour_q;
	logic        v_s1;
	logic [15:0] base_s1;
	logic [15:0] sp_s1;
	logic [16:0] w1p_s1;
	logic [16:0] w2p_s1;

	logic [16:0] a;
	logic signed [17:0] ai;
	logic        neg;

	assign random = cfg.mode[0];
	assign full   = v_s1 && q_full;
	assign accept = push && !full;

	always_comb begin
		st   = cfg.fan_angles[15:0];
		en   = cfg.fan_angles[31:16];
		span = (en > st) ? en - st : 16'd0;
		sp_full  = span * request.rand_angle;
		w1p_full = $signed(cfg.ring_widths[15:0]) * $signed({1'b0, request.rand_x});
		w2p_full = $signed(cfg.ring_widths[31:16]) * $signed({1'b0, request.rand_z});
		ca = {2'b0, contour_q} + {2'b0, cfg.angle_step};
		for (int i = 0; i < 3; i++) begin
			if (ca > DEG360) begin
				ca = ca - DEG360;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			contour_q <= 15'd0;
			v_s1      <= 1'b0;
		end else begin
			if (start_load) begin
				contour_q <= start_val;
			end else if (accept && !random) begin
				contour_q <= ca[14:0];
			end
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (!q_full) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			base_s1 <= random ? st : ca[15:0];
			sp_s1   <= random ? sp_full[31:16] : 16'd0;
			w1p_s1  <= random ? w1p_full[32:16] : 17'd0;
			w2p_s1  <= random ? w2p_full[32:16] : 17'd0;
		end
	end

	// reduce modulo 360 and fold into [-90, 90] for the rotator
	always_comb begin
		a = {1'b0, base_s1} + {1'b0, sp_s1};
		for (int i = 0; i < 5; i++) begin
			if (a >= DEG360) begin
				a = a - DEG360;
			end
		end
		neg = 1'b0;
		if (a > DEG90 && a <= DEG270) begin
			ai  = $signed({1'b0, a}) - $signed({1'b0, DEG180});
			neg = 1'b1;
		end else if (a > DEG270) begin
			ai = $signed({1'b0, a}) - $signed({1'b0, DEG360});
		end else begin
			ai = $signed({1'b0, a});
		end
		q_wdata.z   = {ai[14:0], 10'b0};
		q_wdata.neg = neg;
		q_wdata.r1  = {{2{cfg.radii[15]}}, cfg.radii[15:0]} - {w1p_s1[16], w1p_s1};
		q_wdata.r2  = {{2{cfg.radii[31]}}, cfg.radii[31:16]} - {w2p_s1[16], w2p_s1};
	end

	assign q_wr = v_s1;

endmodule
`default_nettype wire

[design/cep_back.sv]
// Back part: CORDIC sine/cosine, rotation matrix build, rotate, offset and saturate.
`timescale 1ns / 1ps
`default_nettype none
module cep_back
	import cep_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cfg_t        cfg,
	input  wire front_item_t q_rdata,
	input  wire logic        q_empty,
	output logic             q_rd,
	output logic             empty,
	input  wire logic        pop,
	output result_t          result
);

	back_state_t state_q, state_d;

	logic [4:0] cnt_q;
	logic [3:0] rj_q;
	logic [1:0] rrow_q, rcol_q, prow_q, pcol_q;

	logic signed [XY_W-1:0] x_q, y_q;
	logic signed [Z_W-1:0]  z_q;
	logic                   neg_q;
	logic signed [R_W-1:0]  r1_q, r2_q;
	logic signed [PC_W-1:0] pc_q;
	logic signed [COORD_WIDTH-1:0] u_q, t_q;
	logic signed [ACC_M_W-1:0] accm_q;
	logic signed [M_W-1:0]     m_q [9];
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [SUM_W-1:0]   acc_q;
	logic signed [SUM_W-1:0]   sum_q [3];
	logic                      res_v_q;
	result_t                   res_q;

	logic load_in, load_out;

	logic [3:0] ci;
	logic signed [XY_W-1:0] dx, dy, cx, cy, mc;
	logic signed [R_W-1:0]  mr;
	logic signed [63:0]     pc_r;
	logic signed [COORD_WIDTH-1:0] pc_sat;

	mat_op_t op;
	logic [3:0]  mk;
	logic [1:0]  sa, sb;
	logic signed [15:0] qa, qb;
	logic signed [31:0] qp;
	logic signed [ACC_M_W-1:0] twop, mtot;
	logic signed [63:0] m_r;

	logic [3:0] midx;
	logic signed [COORD_WIDTH-1:0] vsel;
	logic signed [SUM_W-1:0] acc_new;

	logic signed [63:0] f_s, f_o;
	logic signed [COORD_WIDTH-1:0] f_c;
	result_t res_d;

	function automatic logic signed [15:0] qsel(input logic [1:0] s, input logic [63:0] r);
		logic signed [15:0] v;
		case (s)
			Q_W:     v = r[63:48];
			Q_X:     v = r[47:32];
			Q_Y:     v = r[31:16];
			default: v = r[15:0];
		endcase
		return v;
	endfunction

	assign empty  = !res_v_q;
	assign result = res_q;
	assign q_rd   = (state_q == BK_IDLE) && !q_empty;

	always_comb begin
		state_d  = state_q;
		load_in  = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					load_in = 1'b1;
					state_d = BK_RUN;
				end
			end
			BK_RUN: begin
				if (cnt_q == 5'd18) begin
					state_d = BK_ROT;
				end
			end
			BK_ROT: begin
				if (rj_q == 4'd9) begin
					state_d = BK_FIN;
				end
			end
			BK_FIN: begin
				if (!res_v_q || pop) begin
					load_out = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			res_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				res_v_q <= 1'b1;
			end else if (pop) begin
				res_v_q <= 1'b0;
			end
		end
	end

	// datapath arithmetic
	always_comb begin
		ci = cnt_q[3:0];
		dx = y_q >>> ci;
		dy = x_q >>> ci;
		cx = neg_q ? -x_q : x_q;
		cy = neg_q ? -y_q : y_q;
		mr = cnt_q[0] ? r2_q : r1_q;
		mc = cnt_q[0] ? cy : cx;
		pc_r   = pc_q;
		pc_r   = (pc_r + (64'sd1 <<< 29)) >>> 30;
		pc_sat = sat_cw(pc_r);

		mk   = cnt_q[4:1];
		op   = mat_op(mk);
		sa   = cnt_q[0] ? op.ic : op.ia;
		sb   = cnt_q[0] ? op.id : op.ib;
		qa   = qsel(sa, cfg.rotation);
		qb   = qsel(sb, cfg.rotation);
		qp   = qa * qb;
		twop = {{(ACC_M_W-33){qp[31]}}, qp, 1'b0};
		mtot = accm_q + (op.neg2 ? -twop : twop);
		m_r  = mtot;
		m_r  = (m_r + 64'sd8192) >>> 14;

		midx = {1'b0, rrow_q, 1'b0} + {2'b0, rrow_q} + {2'b0, rcol_q};
		unique case (cfg.mode[2:1])
			PLANE_XY: vsel = (rcol_q == 2'd0) ? u_q : ((rcol_q == 2'd1) ? t_q : '0);
			PLANE_XZ: vsel = (rcol_q == 2'd0) ? u_q : ((rcol_q == 2'd2) ? t_q : '0);
			default:  vsel = (rcol_q == 2'd1) ? u_q : ((rcol_q == 2'd2) ? t_q : '0);
		endcase
		acc_new = ((pcol_q == 2'd0) ? '0 : acc_q) + SUM_W'(prod_q);

		res_d = '0;
		for (int r = 0; r < 3; r++) begin
			f_s = sum_q[r];
			f_s = (f_s + 64'sd8192) >>> 14;
			f_c = sat_cw(f_s);
			f_o = f_c;
			f_o = f_o + 64'($signed(cfg.offset[16*r +: 16]));
			f_c = sat_cw(f_o);
			f_o = f_c;
			case (r)
				0:       res_d.pos_x = sat16(f_o);
				1:       res_d.pos_y = sat16(f_o);
				default: res_d.pos_z = sat16(f_o);
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_in) begin
			x_q   <= CORDIC_K;
			y_q   <= '0;
			z_q   <= q_rdata.z;
			neg_q <= q_rdata.neg;
			r1_q  <= q_rdata.r1;
			r2_q  <= q_rdata.r2;
			cnt_q <= 5'd0;
		end
		if (state_q == BK_RUN) begin
			cnt_q <= cnt_q + 5'd1;
			if (!cnt_q[4]) begin
				if (!z_q[Z_W-1]) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - atan_q(ci);
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + atan_q(ci);
				end
			end
			if (cnt_q < 5'd18) begin
				if (!cnt_q[0]) begin
					accm_q <= (op.diag ? ONE_Q28 - twop : twop);
				end else begin
					m_q[mk] <= m_r[M_W-1:0];
				end
			end
			if (cnt_q == 5'd16 || cnt_q == 5'd17) begin
				pc_q <= mr * mc;
			end
			if (cnt_q == 5'd17) begin
				u_q <= pc_sat;
			end
			if (cnt_q == 5'd18) begin
				t_q    <= pc_sat;
				rj_q   <= 4'd0;
				rrow_q <= 2'd0;
				rcol_q <= 2'd0;
			end
		end
		if (state_q == BK_ROT) begin
			rj_q <= rj_q + 4'd1;
			if (rj_q < 4'd9) begin
				prod_q <= m_q[midx] * vsel;
				prow_q <= rrow_q;
				pcol_q <= rcol_q;
				if (rcol_q == 2'd2) begin
					rcol_q <= 2'd0;
					rrow_q <= rrow_q + 2'd1;
				end else begin
					rcol_q <= rcol_q + 2'd1;
				end
			end
			if (rj_q != 4'd0) begin
				if (pcol_q == 2'd2) begin
					sum_q[prow_q] <= acc_new;
				end else begin
					acc_q <= acc_new;
				end
			end
		end
		if (load_out) begin
			res_q <= res_d;
		end
	end

endmodule
`default_nettype wire

[tb/sv/tb_circle_emitter_position.sv]
// Testbench for circle_emitter_position: directed and random spawn requests checked against a predictor.
`timescale 1ns / 1ps
module tb_circle_emitter_position
	import cep_pkg::*;
;

	localparam int LIMIT_CYCLES = 1000000;
	localparam int DRAIN_CYCLES = 40;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	request_t    request;
	logic        empty;
	logic        pop;
	result_t     result;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [5:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;

	cfg_t        shadow_cfg;
	int unsigned contour_pos;
	result_t     spawn_q[$];
	int          n_errors;
	int          n_cycles;
	bit          no_idle;

	circle_emitter_position i_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .request(request),
		.empty(empty), .pop(pop), .result(result), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic longint sx16(input logic [15:0] v);
		return longint'($signed(v));
	endfunction

	function automatic longint sat_w(input longint v, input int w);
		longint hi;
		hi = (64'sd1 <<< (w - 1)) - 1;
		if (v > hi) return hi;
		if (v < -hi - 1) return -hi - 1;
		return v;
	endfunction

	function automatic longint round_sh(input longint v, input int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	// CORDIC cos/sin in Q2.30 of a Q10.6 degree angle
	function automatic void cordic_trig(input int unsigned ang, output longint c,
			output longint s);
		longint a;
		longint x;
		longint y;
		longint z;
		longint dx;
		longint dy;
		bit     flip;
		a = longint'(ang % 23040);
		flip = 1'b0;
		if (a > 5760 && a <= 17280) begin
			a -= 11520;
			flip = 1'b1;
		end else if (a > 17280) begin
			a -= 23040;
		end
		x = 652032874;
		y = 0;
		z = a * 1024;
		for (int i = 0; i < 16; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= longint'(atan_q(4'(i)));
			end else begin
				x += dx;
				y -= dy;
				z += longint'(atan_q(4'(i)));
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic result_t predict_spawn(input request_t rq);
		longint      r1;
		longint      r2;
		longint      c;
		longint      s;
		longint      u;
		longint      t;
		longint      p;
		longint      v[3];
		longint      m[9];
		longint      qw;
		longint      qx;
		longint      qy;
		longint      qz;
		longint      o[3];
		int unsigned angle;
		int unsigned st;
		int unsigned en;
		int unsigned span;
		int unsigned plane;
		result_t     res;
		r1 = sx16(shadow_cfg.radii[15:0]);
		r2 = sx16(shadow_cfg.radii[31:16]);
		plane = 32'(shadow_cfg.mode[2:1]);
		if (shadow_cfg.mode[0]) begin
			st = 32'(shadow_cfg.fan_angles[15:0]);
			en = 32'(shadow_cfg.fan_angles[31:16]);
			span = en > st ? en - st : 0;
			angle = st + int'((longint'(span) * longint'(rq.rand_angle)) >> 16);
			r1 -= (sx16(shadow_cfg.ring_widths[15:0]) * longint'(rq.rand_x)) >>> 16;
			r2 -= (sx16(shadow_cfg.ring_widths[31:16]) * longint'(rq.rand_z)) >>> 16;
		end else begin
			angle = contour_pos + shadow_cfg.angle_step;
			while (angle > 23040) angle -= 23040;
			contour_pos = angle & 32'h7FFF;
		end
		cordic_trig(angle, c, s);
		u = sat_w(round_sh(r1 * c, 30), COORD_WIDTH);
		t = sat_w(round_sh(r2 * s, 30), COORD_WIDTH);
		if (plane == PLANE_XY) begin
			v[0] = u; v[1] = t; v[2] = 0;
		end else if (plane == PLANE_XZ) begin
			v[0] = u; v[1] = 0; v[2] = t;
		end else begin
			v[0] = 0; v[1] = u; v[2] = t;
		end
		qw = sx16(shadow_cfg.rotation[63:48]);
		qx = sx16(shadow_cfg.rotation[47:32]);
		qy = sx16(shadow_cfg.rotation[31:16]);
		qz = sx16(shadow_cfg.rotation[15:0]);
		m[0] = (64'sd1 <<< 28) - 2 * (qy * qy + qz * qz);
		m[1] = 2 * (qx * qy - qw * qz);
		m[2] = 2 * (qx * qz + qw * qy);
		m[3] = 2 * (qx * qy + qw * qz);
		m[4] = (64'sd1 <<< 28) - 2 * (qx * qx + qz * qz);
		m[5] = 2 * (qy * qz - qw * qx);
		m[6] = 2 * (qx * qz - qw * qy);
		m[7] = 2 * (qy * qz + qw * qx);
		m[8] = (64'sd1 <<< 28) - 2 * (qx * qx + qy * qy);
		for (int i = 0; i < 9; i++) m[i] = round_sh(m[i], 14);
		for (int i = 0; i < 3; i++) begin
			p = m[i*3] * v[0] + m[i*3+1] * v[1] + m[i*3+2] * v[2];
			o[i] = sat_w(round_sh(p, 14), COORD_WIDTH);
			o[i] += sx16(shadow_cfg.offset[16*i +: 16]);
			o[i] = sat_w(sat_w(o[i], COORD_WIDTH), 16);
		end
		res.pos_x = o[0][15:0];
		res.pos_y = o[1][15:0];
		res.pos_z = o[2][15:0];
		return res;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 50) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// one request; push stays high when no gap follows
	task automatic send_request(input request_t rq);
		int gap;
		push <= 1'b1;
		request <= rq;
		do @(posedge clk); while (full);
		spawn_q.push_back(predict_spawn(rq));
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_rand(input int n);
		request_t rq;
		for (int k = 0; k < n; k++) begin
			rq = request_t'({16'($urandom), $urandom});
			if ($urandom_range(0, 9) == 0) rq.rand_angle = $urandom_range(0, 1) ? 16'hFFFF : 16'h0;
			if ($urandom_range(0, 9) == 0) rq.rand_x = $urandom_range(0, 1) ? 16'hFFFF : 16'h0;
			if ($urandom_range(0, 9) == 0) rq.rand_z = $urandom_range(0, 1) ? 16'hFFFF : 16'h0;
			send_request(rq);
		end
	endtask

	task automatic wait_idle();
		push <= 1'b0;
		while (spawn_q.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_MODE:   shadow_cfg.mode = val[2:0];
			REG_STEP:   shadow_cfg.angle_step = val[14:0];
			REG_START: begin
				shadow_cfg.start_angle = val[14:0];
				contour_pos = 32'(val[14:0]);
			end
			REG_FAN:    shadow_cfg.fan_angles = val[31:0];
			REG_RADII:  shadow_cfg.radii = val[31:0];
			REG_WIDTHS: shadow_cfg.ring_widths = val[31:0];
			REG_ROT:    shadow_cfg.rotation = val;
			default:    shadow_cfg.offset = val[47:0];
		endcase
		// idle cycle so the next write's setup starts on a later edge
		@(posedge clk);
	endtask

	task automatic test_defaults();
		send_request('{16'h0, 16'h0, 16'h0});
		send_request('{16'hFFFF, 16'hFFFF, 16'hFFFF});
		send_rand(3);
		wait_idle();
	endtask

	task automatic test_fan_extremes();
		write_reg(REG_RADII, 64'h7FFF_7FFF);
		write_reg(REG_WIDTHS, 64'h8000_7FFF);
		write_reg(REG_FAN, 64'hFFFF_0000);
		send_request('{16'hFFFF, 16'hFFFF, 16'hFFFF});
		send_request('{16'h0, 16'h0, 16'h0});
		send_request('{16'h8000, 16'h8000, 16'h8000});
		wait_idle();
		// reversed fan collapses to the start angle, which lies past 360 degrees
		write_reg(REG_FAN, 64'h1000_B400);
		write_reg(REG_RADII, 64'h8000_F000);
		send_request('{16'hFFFF, 16'h1234, 16'hFFFF});
		send_request('{16'h0, 16'h0, 16'h0});
		wait_idle();
	endtask

	task automatic test_planes_rotation();
		write_reg(REG_RADII, 64'h0C80_0640);
		write_reg(REG_WIDTHS, 64'h0);
		write_reg(REG_FAN, 64'h5A00_0000);
		write_reg(REG_ROT, 64'h2D41_2D41_0000_0000);
		write_reg(REG_OFF, 64'h8000_7FFF_0100);
		for (int pl = 0; pl < 4; pl++) begin
			write_reg(REG_MODE, 64'(pl * 2 + 1));
			send_rand(2);
			wait_idle();
		end
		// non-unit quaternion drives the rotation into saturation
		write_reg(REG_ROT, 64'h7FFF_8000_7FFF_8000);
		write_reg(REG_RADII, 64'h7FFF_8000);
		send_rand(2);
		wait_idle();
	endtask

	task automatic test_contour();
		write_reg(REG_ROT, 64'h4000_0000_0000_0000);
		write_reg(REG_OFF, 64'h0);
		write_reg(REG_RADII, 64'h0800_0800);
		write_reg(REG_MODE, 64'h0);
		write_reg(REG_STEP, 64'd23040);
		write_reg(REG_START, 64'd23040);
		send_rand(2);
		wait_idle();
		write_reg(REG_STEP, 64'd0);
		write_reg(REG_START, 64'd0);
		send_rand(2);
		wait_idle();
		write_reg(REG_MODE, 64'h6);
		write_reg(REG_STEP, 64'd11521);
		write_reg(REG_START, 64'd17000);
		send_rand(4);
		wait_idle();
	endtask

	task automatic test_random_phases();
		logic [63:0] rot;
		for (int ph = 0; ph < 24; ph++) begin
			no_idle = (ph % 6 == 5);
			write_reg(REG_MODE, 64'($urandom_range(0, 7)));
			write_reg(REG_STEP, 64'($urandom_range(0, 23040)));
			write_reg(REG_START, 64'($urandom_range(0, 23040)));
			write_reg(REG_FAN, 64'($urandom));
			if ($urandom_range(0, 3) == 0)
				write_reg(REG_RADII, 64'($urandom));
			else
				write_reg(REG_RADII, {32'h0, 16'($urandom_range(0, 16383)),
					16'($urandom_range(0, 16383))});
			write_reg(REG_WIDTHS, 64'($urandom));
			case ($urandom_range(0, 3))
				0: rot = 64'h4000_0000_0000_0000;
				1: rot = 64'h2D41_0000_2D41_0000;
				2: rot = 64'h2000_2000_2000_2000;
				default: rot = {$urandom, $urandom};
			endcase
			write_reg(REG_ROT, rot);
			write_reg(REG_OFF, {16'h0, $urandom, 16'($urandom)} & 64'hFFFF_FFFF_FFFF);
			send_rand(40);
			wait_idle();
		end
		no_idle = 1'b0;
	endtask

	// result side: pop with random stalls
	initial begin
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			int gap;
			pop <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			gap = pick_gap();
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (spawn_q.size() == 0) begin
				n_errors++;
				if (n_errors <= 10) $display("unexpected position %h", result);
			end else begin
				result_t exp_pos;
				exp_pos = spawn_q.pop_front();
				if (result.pos_x !== exp_pos.pos_x || result.pos_y !== exp_pos.pos_y ||
						result.pos_z !== exp_pos.pos_z) begin
					n_errors++;
					if (n_errors <= 10)
						$display("position mismatch: expected x=%0d y=%0d z=%0d got x=%0d y=%0d z=%0d",
							exp_pos.pos_x, exp_pos.pos_y, exp_pos.pos_z,
							result.pos_x, result.pos_y, result.pos_z);
				end
			end
		end
	end

	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > LIMIT_CYCLES) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		n_errors = 0;
		n_cycles = 0;
		no_idle = 1'b0;
		arst_n = 1'b0;
		push = 1'b0;
		request = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		shadow_cfg = '{RST_MODE, RST_STEP, RST_START, RST_FAN, RST_RADII, RST_WIDTHS,
			RST_ROT, RST_OFF};
		contour_pos = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_defaults();
		test_fan_extremes();
		test_planes_rotation();
		test_contour();
		test_random_phases();
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_errors == 0 && spawn_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[filelist.f]
design/cep_pkg.sv
design/cep_queue.sv
design/cep_front.sv
design/cep_back.sv
design/circle_emitter_position.sv
tb/sv/tb_circle_emitter_position.sv
